// ----- src/assert_macros.svh -----
// Assertion shorthands for the RTL files; the scan controller unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_IMPLY(label, clk, rst, cond, expr)

`define ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ----- src/ssc_pkg.sv -----
package ssc_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int SLOT_W      = $clog2(DIGIT_COUNT + 1);
  localparam int DIGIT_W     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  localparam int KIND_W   = 2;
  localparam int NUMBER_W = 14;
  localparam int SEL_W    = 2;
  localparam int SEG_W    = 8;
  localparam int LEVEL_W  = 8;
  localparam int TIMER_W  = 16;
  localparam int PHASE_W  = 17;
  localparam int BCD_W    = 4;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RAW    = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [SEG_W-1:0]   SEG_ALL   = 8'hFF;
  localparam logic [SEG_W-1:0]   SEG_NO_DP = 8'h7F;
  localparam logic [SEG_W-1:0]   SEG_DP    = 8'h80;

  // Configuration register map, one 32-bit word per register.
  localparam int REG_COUNT  = 7;
  localparam int ADDR_W     = $clog2(4 * REG_COUNT);
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam int DATA_W     = 32;

  localparam logic [REG_IDX_W-1:0] REG_COMMON_ANODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DWELL_TICKS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_HALF   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_MASK   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HAS_POINT    = 3'd6;

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint NUMBER_LIMIT = pow10(DIGIT_COUNT) - 1;

  // Fixed-point shift for the reciprocal multiplies that split a number into decimal digits.
  localparam int RECIP_SHIFT = NUMBER_W + $clog2(pow10(DIGIT_COUNT - 1)) + 1;

  function automatic logic [SEG_W-1:0] seg_of(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

  typedef logic [DIGIT_COUNT-1:0][SEG_W-1:0] pattern_set_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [NUMBER_W-1:0] number;
    logic                leading_zeros;
    logic [SEL_W-1:0]    digit_select;
    logic [SEG_W-1:0]    raw_pattern;
  } ssc_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  scan_slot;
    logic               digit_lit;
    logic [SEG_W-1:0]   segment_lines;
    logic [LEVEL_W-1:0] common_level;
  } ssc_out_t;

  typedef struct packed {
    logic         in_range;
    pattern_set_t patterns;
  } ssc_load_t;

endpackage

// ----- src/seven_segment_scan_controller_unit.sv -----
// An accepted item is held in the input register, and its result is registered into the output
// register once the output is not stalled.
// Throughput: one item per cycle unless the output stalls; an input skid register then keeps an item.
// The decimal split uses parallel reciprocal multiplies, one multiplier deep per stage.
// Reset is synchronous and active high: registers take their defaults, patterns go blank,
// the scan starts at digit 0, and the dwell and blink counters clear.
`include "assert_macros.svh"

module seven_segment_scan_controller_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ssc_pkg::ssc_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ssc_pkg::ssc_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ssc_pkg::DATA_W-1:0]   pwdata,
  output logic [ssc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import ssc_pkg::*;

  // Configuration registers.
  logic                   common_anode;
  logic [LEVEL_W-1:0]     brightness;
  logic [TIMER_W-1:0]     dwell_ticks;
  logic [TIMER_W-1:0]     blink_half_period;
  logic [DIGIT_COUNT-1:0] enable_mask;
  logic [DIGIT_COUNT-1:0] blink_mask;
  logic                   has_point;

  // Scan state.
  pattern_set_t       patterns;
  pattern_set_t       patterns_next;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  slot_next;
  logic [TIMER_W-1:0] dwell;
  logic [TIMER_W-1:0] dwell_next;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;

  // Input register and skid register.
  ssc_in_t a_item;
  logic    a_valid;
  ssc_in_t b_item;
  logic    b_valid;

  ssc_out_t  result;
  ssc_load_t load;
  logic      cfg_write;
  logic      in_accept;
  logic      adv;

  logic [TIMER_W-1:0]   half;
  logic [TIMER_W-1:0]   dwell_limit;
  logic [PHASE_W:0]     phase_inc;
  logic [PHASE_W:0]     period;
  logic [TIMER_W:0]     dwell_inc;
  logic [SLOT_W-1:0]    adv_slot;
  logic [DIGIT_W-1:0]   idx;
  logic                 lit;
  logic [SEG_W-1:0]     seg_on;

  function automatic logic [SLOT_W-1:0] first_after(input logic [SLOT_W-1:0] start,
                                                    input logic [DIGIT_COUNT-1:0] mask);
    logic [SLOT_W-1:0] r;
    r = SLOT_W'(DIGIT_COUNT);
    for (int d = DIGIT_COUNT - 1; d >= 0; d--) begin
      if (mask[d] && (SLOT_W'(d) >= start)) begin
        r = SLOT_W'(d);
      end
    end
    return r;
  endfunction

  ssc_digits u_digits (
    .number        (a_item.number),
    .leading_zeros (a_item.leading_zeros),
    .load          (load)
  );

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      common_anode      <= 1'b0;
      brightness        <= LEVEL_MAX;
      dwell_ticks       <= 16'd5;
      blink_half_period <= 16'd500;
      enable_mask       <= '1;
      blink_mask        <= '0;
      has_point         <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[ADDR_W-1:2])
        REG_COMMON_ANODE: common_anode      <= pwdata[0];
        REG_BRIGHTNESS:   brightness        <= pwdata[LEVEL_W-1:0];
        REG_DWELL_TICKS:  dwell_ticks       <= pwdata[TIMER_W-1:0];
        REG_BLINK_HALF:   blink_half_period <= pwdata[TIMER_W-1:0];
        REG_ENABLE_MASK:  enable_mask       <= pwdata[DIGIT_COUNT-1:0];
        REG_BLINK_MASK:   blink_mask        <= pwdata[DIGIT_COUNT-1:0];
        REG_HAS_POINT:    has_point         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_COMMON_ANODE: prdata = DATA_W'(common_anode);
      REG_BRIGHTNESS:   prdata = DATA_W'(brightness);
      REG_DWELL_TICKS:  prdata = DATA_W'(dwell_ticks);
      REG_BLINK_HALF:   prdata = DATA_W'(blink_half_period);
      REG_ENABLE_MASK:  prdata = DATA_W'(enable_mask);
      REG_BLINK_MASK:   prdata = DATA_W'(blink_mask);
      REG_HAS_POINT:    prdata = DATA_W'(has_point);
      default:          prdata = '0;
    endcase
  end

  // Handshake: the skid register catches an item that arrives while the input register waits.
  assign in_stall  = b_valid;
  assign in_accept = in_valid && !in_stall;
  assign adv       = a_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= b_valid || in_accept;
      b_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= b_valid ? b_item : in_data;
    end else if (in_accept && !a_valid) begin
      a_item <= in_data;
    end
    if (in_accept && a_valid && !adv) begin
      b_item <= in_data;
    end
  end

  // Next scan state for the item in the input register.
  assign half        = (blink_half_period == '0) ? TIMER_W'(1) : blink_half_period;
  assign dwell_limit = (dwell_ticks == '0) ? TIMER_W'(1) : dwell_ticks;
  assign phase_inc   = {1'b0, phase} + (PHASE_W + 1)'(1);
  assign period      = {1'b0, half, 1'b0};
  assign dwell_inc   = {1'b0, dwell} + (TIMER_W + 1)'(1);
  assign adv_slot    = (slot >= SLOT_W'(DIGIT_COUNT)) ? first_after('0, enable_mask)
                                                      : first_after(slot + SLOT_W'(1), enable_mask);

  always_comb begin
    patterns_next = patterns;
    slot_next     = slot;
    dwell_next    = dwell;
    phase_next    = phase;
    case (a_item.kind)
      KIND_TICK: begin
        if (phase_inc >= period) begin
          phase_next = '0;
        end else begin
          phase_next = phase_inc[PHASE_W-1:0];
        end
        if (dwell_inc >= {1'b0, dwell_limit}) begin
          dwell_next = '0;
          slot_next  = adv_slot;
        end else begin
          dwell_next = dwell_inc[TIMER_W-1:0];
        end
      end
      KIND_NUMBER: begin
        if (load.in_range) begin
          patterns_next = load.patterns;
        end
      end
      KIND_RAW: begin
        if (32'(a_item.digit_select) < DIGIT_COUNT) begin
          patterns_next[DIGIT_W'(a_item.digit_select)] = a_item.raw_pattern;
        end
      end
      default: ;
    endcase
  end

  // Drive for the state after the item.
  assign idx = DIGIT_W'(slot_next);
  assign lit = (slot_next < SLOT_W'(DIGIT_COUNT)) && enable_mask[idx] &&
               !(blink_mask[idx] && (phase_next >= {1'b0, half}));
  assign seg_on = lit ? (patterns_next[idx] & (has_point ? SEG_ALL : SEG_NO_DP)) : '0;

  always_comb begin
    result.scan_slot = slot_next;
    result.digit_lit = lit;
    if (common_anode) begin
      result.segment_lines = ~seg_on | (has_point ? '0 : SEG_DP);
      result.common_level  = lit ? brightness : '0;
    end else begin
      result.segment_lines = seg_on;
      result.common_level  = lit ? (LEVEL_MAX - brightness) : LEVEL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      patterns  <= '0;
      slot      <= '0;
      dwell     <= '0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      patterns  <= patterns_next;
      slot      <= slot_next;
      dwell     <= dwell_next;
      phase     <= phase_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

  `ASSERT_IMPLY(a_skid_needs_main, clk, rst, b_valid, a_valid)
  `ASSERT_ALWAYS(a_slot_range, clk, rst, slot <= SLOT_W'(DIGIT_COUNT))
  `ASSERT_IMPLY(a_lit_on_digit, clk, rst, out_valid && out_data.digit_lit, out_data.scan_slot < SLOT_W'(DIGIT_COUNT))
  `ASSERT_NEXT(a_adv_fills_out, clk, rst, adv, out_valid)

endmodule

// ----- src/ssc_digits.sv -----
module ssc_digits (
  input  logic [ssc_pkg::NUMBER_W-1:0] number,
  input  logic                         leading_zeros,
  output ssc_pkg::ssc_load_t           load
);
  import ssc_pkg::*;

  logic [NUMBER_W-1:0] quot [DIGIT_COUNT+1];
  logic [BCD_W-1:0]    vals [DIGIT_COUNT];
  logic                lead;

  assign quot[0]           = number;
  assign quot[DIGIT_COUNT] = '0;

  // Each quotient by a power of ten is one reciprocal multiply, all in parallel.
  for (genvar i = 1; i < DIGIT_COUNT; i++) begin : g_quot
    localparam longint DIV = pow10(i);
    localparam logic [RECIP_SHIFT-1:0] RECIP =
      RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) / DIV) + 1);
    logic [NUMBER_W+RECIP_SHIFT-1:0] prod;
    assign prod    = {{RECIP_SHIFT{1'b0}}, number} * {{NUMBER_W{1'b0}}, RECIP};
    assign quot[i] = prod[NUMBER_W+RECIP_SHIFT-1:RECIP_SHIFT];
  end

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
    logic [NUMBER_W+2:0] tens;
    logic [NUMBER_W+2:0] diff;
    assign tens    = {quot[i+1], 3'b000} + {2'b00, quot[i+1], 1'b0};
    assign diff    = {3'b000, quot[i]} - tens;
    assign vals[i] = diff[BCD_W-1:0];
  end

  // Unless leading_zeros is set, blank zeros from the most significant digit down until the first nonzero one.
  always_comb begin
    lead = !leading_zeros;
    load.in_range = (64'(number) <= NUMBER_LIMIT);
    load.patterns = '0;
    for (int k = DIGIT_COUNT - 1; k >= 0; k--) begin
      if (vals[k] == '0 && lead) begin
        load.patterns[k] = '0;
      end else begin
        load.patterns[k] = seg_of(vals[k]);
        lead = 1'b0;
      end
    end
  end

endmodule
